// ===== sv/hsv2rgb_pkg.sv =====
// hsv2rgb_pkg: shared widths, sector codes and constants of the hsv to rgb core
// no dependencies, compiled first
package hsv2rgb_pkg;

  localparam int unsigned CHAN_W = 8;   // width of one color channel code
  localparam int unsigned ACC_W  = 17;  // rounded numerator over 2^hue_bits, before /255

  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;
  // rounding bias of the p channel once the 2^hue_bits factor is dropped
  localparam logic [ACC_W-1:0]  P_RND    = 17'd127;

  // hue sextant, integer part of hue*6
  typedef enum logic [2:0] {
    SECT_R_Y = 3'd0,
    SECT_Y_G = 3'd1,
    SECT_G_C = 3'd2,
    SECT_C_B = 3'd3,
    SECT_B_M = 3'd4,
    SECT_M_R = 3'd5
  } sector_e;

  // one rgb pixel as it leaves the core
  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

endpackage

// ===== sv/hsv2rgb_if.sv =====
// hsv2rgb_hsv_if and hsv2rgb_rgb_if: valid/ready channels of the hsv to rgb core
// depends on hsv2rgb_pkg
interface hsv2rgb_hsv_if
  import hsv2rgb_pkg::*;
#(
  parameter int unsigned HUE_BITS = 16
);
  logic                valid;
  logic                ready;
  logic [HUE_BITS-1:0] hue;
  logic [CHAN_W-1:0]   saturation;
  logic [CHAN_W-1:0]   brightness;

  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

interface hsv2rgb_rgb_if
  import hsv2rgb_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

// ===== sv/hsv2rgb_chan.sv =====
// hsv2rgb_chan: divides a rounded channel numerator by 255 and clamps to a code
// depends on hsv2rgb_pkg
module hsv2rgb_chan
  import hsv2rgb_pkg::*;
(
  input  logic [ACC_W-1:0]  acc_i,
  output logic [CHAN_W-1:0] code_o
);

  logic [ACC_W-1:0]  sum;
  logic [ACC_W-9:0]  quo;

  // floor(x/255) = (x + (x>>8) + 1) >> 8 over the range used here
  assign sum    = acc_i + (acc_i >> 8) + ACC_W'(1);
  assign quo    = sum[ACC_W-1:8];
  assign code_o = (quo > (ACC_W-8)'(CHAN_MAX)) ? CHAN_MAX : quo[CHAN_W-1:0];

endmodule

// ===== sv/hsv_to_rgb_pixel_core.sv =====
// hsv_to_rgb_pixel_core: four-stage pipelined hsv to 8-bit rgb conversion
// depends on hsv2rgb_pkg, hsv2rgb_if (both interfaces) and hsv2rgb_chan
//
//   channel  dir  modport  payload                            beat
//   hsv_i    in   sink     hue, saturation, brightness        one pixel
//   rgb_o    out  source   red, green, blue                   one pixel
//
// one beat per clock sustained while rgb_o.ready stays high; an accepted beat passes s1, s2, s3 and rgb_q
// stages: hue*6 split, frac*sat multiply, value multiply and round, /255 and select
// each stage holds while the next one is full and held, so a stalled rgb_o keeps its beat
// and bubbles still close up; hsv_i.ready drops only when all four stages hold data
// rst_ni clears the valid bits only; data registers carry no reset
module hsv_to_rgb_pixel_core
  import hsv2rgb_pkg::*;
#(
  parameter int unsigned HUE_BITS = 16
)(
  input  logic         clk_i,
  input  logic         rst_ni,
  hsv2rgb_hsv_if.sink  hsv_i,
  hsv2rgb_rgb_if.source rgb_o
);

  localparam int unsigned K_W = HUE_BITS + 8;   // factor k, up to 255*2^hue_bits
  localparam int unsigned M_W = K_W + 8;        // value times factor
  localparam int unsigned P_W = M_W + 1;        // plus rounding bias

  typedef logic [K_W-1:0] fac_t;
  typedef logic [P_W-1:0] num_t;

  // 255 * 2^hue_bits, the common denominator
  localparam fac_t FULL_K = {CHAN_MAX, {HUE_BITS{1'b0}}};
  // half the denominator, added before the floor for round half up
  localparam num_t RND    = num_t'(CHAN_MAX) << (HUE_BITS - 1);

  // per-stage load enables, ready ripples back from the output register
  logic ld1, ld2, ld3, ld4;

  logic out_valid_q, s1_valid_q, s2_valid_q, s3_valid_q;

  assign ld4 = !out_valid_q || rgb_o.ready;
  assign ld3 = !s3_valid_q  || ld4;
  assign ld2 = !s2_valid_q  || ld3;
  assign ld1 = !s1_valid_q  || ld2;

  assign hsv_i.ready = ld1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ld1) s1_valid_q  <= hsv_i.valid;
      if (ld2) s2_valid_q  <= s1_valid_q;
      if (ld3) s3_valid_q  <= s2_valid_q;
      if (ld4) out_valid_q <= s3_valid_q;
    end
  end

  // ---------------- stage 1: hue*6 into sector and fraction ----------------
  logic [HUE_BITS+2:0] h6;
  logic [2:0]          s1_sector_q;
  logic [HUE_BITS-1:0] s1_frac_q;
  logic [CHAN_W-1:0]   s1_sat_q, s1_val_q;

  // hue*6 as hue*4 + hue*2
  assign h6 = ({3'b000, hsv_i.hue} << 2) + ({3'b000, hsv_i.hue} << 1);

  always_ff @(posedge clk_i) begin
    if (ld1) begin
      s1_sector_q <= h6[HUE_BITS+2:HUE_BITS];
      s1_frac_q   <= h6[HUE_BITS-1:0];
      s1_sat_q    <= hsv_i.saturation;
      s1_val_q    <= hsv_i.brightness;
    end
  end

  // ---------------- stage 2: f*s and the q, t factors ----------------
  // kq = 255*2^h - f*s, kt = 255*2^h - (2^h - f)*s = kp + f*s
  fac_t              fs, kp;
  logic [2:0]        s2_sector_q;
  logic [CHAN_W-1:0] s2_val_q, s2_pk_q;
  fac_t              s2_kq_q, s2_kt_q;

  assign fs = s1_frac_q * s1_sat_q;
  assign kp = {CHAN_MAX - s1_sat_q, {HUE_BITS{1'b0}}};

  always_ff @(posedge clk_i) begin
    if (ld2) begin
      s2_sector_q <= s1_sector_q;
      s2_val_q    <= s1_val_q;
      s2_pk_q     <= CHAN_MAX - s1_sat_q;
      s2_kq_q     <= FULL_K - fs;
      s2_kt_q     <= kp + fs;
    end
  end

  // ---------------- stage 3: value products, rounded, 2^h dropped ----------------
  logic [M_W-1:0]      mq, mt;
  num_t                nq, nt;
  logic [2*CHAN_W-1:0] mp;
  logic [2:0]          s3_sector_q;
  logic [CHAN_W-1:0]   s3_val_q;
  logic [ACC_W-1:0]    s3_yp_q, s3_yq_q, s3_yt_q;

  assign mq = s2_val_q * s2_kq_q;
  assign mt = s2_val_q * s2_kt_q;
  assign nq = num_t'(mq) + RND;
  assign nt = num_t'(mt) + RND;
  // p factor is a whole multiple of 2^h, so its bias reduces to 127
  assign mp = s2_val_q * s2_pk_q;

  always_ff @(posedge clk_i) begin
    if (ld3) begin
      s3_sector_q <= s2_sector_q;
      s3_val_q    <= s2_val_q;
      s3_yp_q     <= ACC_W'(mp) + P_RND;
      s3_yq_q     <= nq[P_W-1:HUE_BITS];
      s3_yt_q     <= nt[P_W-1:HUE_BITS];
    end
  end

  // ---------------- stage 4: /255, clamp and sector select ----------------
  logic [CHAN_W-1:0] cp, cq, ct, cv;
  rgb_t              rgb_d, rgb_q;

  hsv2rgb_chan u_chan_p (.acc_i(s3_yp_q), .code_o(cp));
  hsv2rgb_chan u_chan_q (.acc_i(s3_yq_q), .code_o(cq));
  hsv2rgb_chan u_chan_t (.acc_i(s3_yt_q), .code_o(ct));

  // full factor rounds back to the value code exactly
  assign cv = s3_val_q;

  always_comb begin
    case (sector_e'(s3_sector_q))
      SECT_R_Y: rgb_d = '{red: cv, green: ct, blue: cp};
      SECT_Y_G: rgb_d = '{red: cq, green: cv, blue: cp};
      SECT_G_C: rgb_d = '{red: cp, green: cv, blue: ct};
      SECT_C_B: rgb_d = '{red: cp, green: cq, blue: cv};
      SECT_B_M: rgb_d = '{red: ct, green: cp, blue: cv};
      default:  rgb_d = '{red: cv, green: cp, blue: cq};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ld4) rgb_q <= rgb_d;
  end

  assign rgb_o.valid = out_valid_q;
  assign rgb_o.red   = rgb_q.red;
  assign rgb_o.green = rgb_q.green;
  assign rgb_o.blue  = rgb_q.blue;

endmodule

// ===== sv/hsv2rgb_checker.sv =====
// hsv2rgb_checker: port-level assertions of hsv_to_rgb_pixel_core, bound to it
// depends on hsv2rgb_pkg and hsv_to_rgb_pixel_core
module hsv2rgb_checker
  import hsv2rgb_pkg::*;
#(
  parameter int unsigned HUE_BITS = 16
)(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic [HUE_BITS-1:0] hue_i,
  input logic [CHAN_W-1:0]   sat_i,
  input logic [CHAN_W-1:0]   val_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [CHAN_W-1:0]   red_i,
  input logic [CHAN_W-1:0]   green_i,
  input logic [CHAN_W-1:0]   blue_i
);

  logic in_acc;

  assign in_acc = in_valid_i && in_ready_i;

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(red_i) && $stable(green_i)
                                    && $stable(blue_i))
    else $error("output beat changed while stalled");

  // free-flowing pipe, rgb_o ready throughout, shows the accepted beat on rgb_o
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i |=> out_valid_i)
    else $error("accepted beat did not reach the output in time");

  // zero saturation gives grey at the value code
  a_grey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && sat_i == '0 ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i |=>
      red_i == $past(val_i, 4) && green_i == $past(val_i, 4) && blue_i == $past(val_i, 4))
    else $error("zero saturation did not give grey");

  // zero value gives black whatever the hue
  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && val_i == '0 ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i |=>
      red_i == '0 && green_i == '0 && blue_i == '0)
    else $error("zero value did not give black");

  // hue does not otherwise feed the checks
  logic unused_hue;
  assign unused_hue = ^hue_i;

endmodule

bind hsv_to_rgb_pixel_core hsv2rgb_checker #(.HUE_BITS(HUE_BITS)) u_hsv2rgb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (hsv_i.valid),
  .in_ready_i  (hsv_i.ready),
  .hue_i       (hsv_i.hue),
  .sat_i       (hsv_i.saturation),
  .val_i       (hsv_i.brightness),
  .out_valid_i (rgb_o.valid),
  .out_ready_i (rgb_o.ready),
  .red_i       (rgb_o.red),
  .green_i     (rgb_o.green),
  .blue_i      (rgb_o.blue)
);

// ===== test/tb_hsv_to_rgb_pixel_core.sv =====
// tb_hsv_to_rgb_pixel_core: self-checking testbench of the hsv to rgb pixel core
// uses hsv2rgb_pkg, both hsv2rgb interfaces and the core; predicts every rgb beat
// from the accepted hsv beats and compares the results in order, under random idling
module tb_hsv_to_rgb_pixel_core;
  import hsv2rgb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HUE_BITS       = 16;
  localparam int unsigned RANDOM_PIXELS  = 600;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES   = 8;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_beat_t;

  // expected rgb beats, in accept order, and the conversion that fills them
  class pixel_scoreboard;
    rgb_beat_t   pending_rgb[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    // v * k / (255 * 2^hue_bits), round half up, clamp
    function logic [CHAN_W-1:0] scale_channel(logic [CHAN_W-1:0] code, logic [63:0] factor);
      logic [63:0] den;
      logic [63:0] quot;
      den  = 64'(255) << HUE_BITS;
      quot = (64'(code) * factor + den / 2) / den;
      return (quot > 64'(CHAN_MAX)) ? CHAN_MAX : quot[CHAN_W-1:0];
    endfunction

    function rgb_beat_t hsv_to_rgb(logic [HUE_BITS-1:0] hue, logic [CHAN_W-1:0] sat,
                                   logic [CHAN_W-1:0] val);
      logic [63:0] one;
      logic [63:0] hue6;
      logic [63:0] frac;
      logic [63:0] full;
      logic [CHAN_W-1:0] cv, cp, cq, ct;
      sector_e sect;
      rgb_beat_t px;
      one  = 64'(1) << HUE_BITS;
      hue6 = 64'(hue) * 64'(6);
      sect = sector_e'(3'(hue6 >> HUE_BITS));
      frac = hue6 & (one - 64'(1));
      full = 64'(255) * one;
      cv = scale_channel(val, full);
      cp = scale_channel(val, (64'(255) - 64'(sat)) * one);
      cq = scale_channel(val, full - frac * 64'(sat));
      ct = scale_channel(val, full - (one - frac) * 64'(sat));
      case (sect)
        SECT_R_Y: px = '{red: cv, green: ct, blue: cp};
        SECT_Y_G: px = '{red: cq, green: cv, blue: cp};
        SECT_G_C: px = '{red: cp, green: cv, blue: ct};
        SECT_C_B: px = '{red: cp, green: cq, blue: cv};
        SECT_B_M: px = '{red: ct, green: cp, blue: cv};
        default:  px = '{red: cv, green: cp, blue: cq};
      endcase
      return px;
    endfunction

    function void note_pixel(logic [HUE_BITS-1:0] hue, logic [CHAN_W-1:0] sat,
                             logic [CHAN_W-1:0] val);
      pending_rgb.push_back(hsv_to_rgb(hue, sat, val));
    endfunction

    function void check_pixel(rgb_beat_t got);
      rgb_beat_t want;
      if (pending_rgb.size() == 0) begin
        $error("rgb beat with no pixel pending: red %0d green %0d blue %0d",
               got.red, got.green, got.blue);
        mismatches++;
        return;
      end
      want = pending_rgb.pop_front();
      if (got.red !== want.red) begin
        $error("red: expected %0d, actual %0d", want.red, got.red);
        mismatches++;
      end
      if (got.green !== want.green) begin
        $error("green: expected %0d, actual %0d", want.green, got.green);
        mismatches++;
      end
      if (got.blue !== want.blue) begin
        $error("blue: expected %0d, actual %0d", want.blue, got.blue);
        mismatches++;
      end
    endfunction

    function int unsigned pending_count();
      return pending_rgb.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  hsv2rgb_hsv_if #(.HUE_BITS(HUE_BITS)) hsv_bus ();
  hsv2rgb_rgb_if rgb_bus ();

  pixel_scoreboard board;
  int unsigned     burst_left;

  hsv_to_rgb_pixel_core #(
    .HUE_BITS(HUE_BITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .hsv_i (hsv_bus),
    .rgb_o (rgb_bus)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // note accepted hsv beats and check accepted rgb beats, both at the edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hsv_bus.valid && hsv_bus.ready) begin
        board.note_pixel(hsv_bus.hue, hsv_bus.saturation, hsv_bus.brightness);
      end
      if (rgb_bus.valid && rgb_bus.ready) begin
        board.check_pixel('{red: rgb_bus.red, green: rgb_bus.green, blue: rgb_bus.blue});
      end
    end
  end

  // ends the run when no beat moves on either side for too long
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    @(posedge rst_ni);
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((hsv_bus.valid && hsv_bus.ready) || (rgb_bus.valid && rgb_bus.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Verification failed");
    $finish;
  end

  // receiver: back-pressure pattern is picked anew at random intervals
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    int unsigned phase;
    rgb_bus.ready = 1'b0;
    mode      = 0;
    mode_left = 0;
    phase     = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(32, 200);
      end
      mode_left--;
      phase++;
      case (mode)
        0:       rgb_bus.ready <= 1'b1;
        1:       rgb_bus.ready <= 1'($urandom_range(0, 1));
        2:       rgb_bus.ready <= (phase % 4 != 3);
        default: rgb_bus.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // present one pixel and hold it until the core takes it
  task automatic send_pixel(input logic [HUE_BITS-1:0] hue, input logic [CHAN_W-1:0] sat,
                            input logic [CHAN_W-1:0] val);
    hsv_bus.valid      <= 1'b1;
    hsv_bus.hue        <= hue;
    hsv_bus.saturation <= sat;
    hsv_bus.brightness <= val;
    @(posedge clk_i);
    while (!hsv_bus.ready) @(posedge clk_i);
  endtask

  // bursts of beats with random gaps, now and then a long stretch with no gap
  task automatic drive_pixel(input logic [HUE_BITS-1:0] hue, input logic [CHAN_W-1:0] sat,
                             input logic [CHAN_W-1:0] val);
    int unsigned gap;
    send_pixel(hue, sat, val);
    if (burst_left == 0) begin
      gap = $urandom_range(1, 10);
      hsv_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120) : $urandom_range(0, 16);
    end else begin
      burst_left--;
    end
  endtask

  // hold off the sender until every pixel has come out
  task automatic wait_drained();
    hsv_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (board.pending_count() != 0) @(posedge clk_i);
  endtask

  function automatic logic [CHAN_W-1:0] pick_code();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CHAN_MAX;
      default: return CHAN_W'($urandom);
    endcase
  endfunction

  initial begin
    board      = new();
    burst_left = 0;
    rst_ni             = 1'b0;
    hsv_bus.valid      = 1'b0;
    hsv_bus.hue        = '0;
    hsv_bus.saturation = '0;
    hsv_bus.brightness = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: hue extremes and sector edges, grey, black, full color
    drive_pixel(16'h0000, 8'd255, 8'd255);
    drive_pixel(16'hFFFF, 8'd255, 8'd255);
    drive_pixel(16'd10922, 8'd255, 8'd255);
    drive_pixel(16'd10923, 8'd255, 8'd255);
    drive_pixel(16'd21845, 8'd200, 8'd180);
    drive_pixel(16'd21846, 8'd200, 8'd180);
    drive_pixel(16'd32767, 8'd128, 8'd255);
    drive_pixel(16'd32768, 8'd128, 8'd255);
    drive_pixel(16'd43690, 8'd255, 8'd100);
    drive_pixel(16'd43691, 8'd255, 8'd100);
    drive_pixel(16'd54613, 8'd1, 8'd254);
    drive_pixel(16'd54614, 8'd254, 8'd1);
    // zero saturation gives grey at the value code
    drive_pixel(16'h1234, 8'd0, 8'd200);
    drive_pixel(16'hBEEF, 8'd0, 8'd255);
    drive_pixel(16'h8000, 8'd0, 8'd0);
    // zero value gives black whatever the hue, then small and mid value codes
    drive_pixel(16'h5555, 8'd255, 8'd0);
    drive_pixel(16'hAAAA, 8'd0, 8'd1);
    drive_pixel(16'hFFFF, 8'd0, 8'd0);
    drive_pixel(16'h0001, 8'd255, 8'd1);
    drive_pixel(16'h7FFF, 8'd127, 8'd127);
    wait_drained();

    for (int unsigned n = 0; n < RANDOM_PIXELS; n++) begin
      drive_pixel(HUE_BITS'($urandom), pick_code(), pick_code());
      if (n == RANDOM_PIXELS / 2) begin
        wait_drained();
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
